// ===== rtl/lae_pkg.sv =====
// lae_pkg: shared types, constants and the ring index helper for the line assembler
// used by lae_front, lae_back, lae_outq and line_assembler_with_backspace_top
// no dependencies
package lae_pkg;

  // line and store geometry
  localparam int LINE_MAX    = 64;
  localparam int STORE_DEPTH = 64;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(LINE_MAX + 1);
  localparam int CHAR_W      = 7;
  localparam int BYTE_W      = 8;

  // received byte codes
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] BYTE_BS    = 8'd8;
  localparam logic [BYTE_W-1:0] BYTE_DEL   = 8'd127;
  localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;

  // command passed from the front to the back
  typedef enum logic [1:0] {
    OP_APPEND,
    OP_BKSP,
    OP_LFEED
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] ch;
  } op_t;

  // one result beat
  typedef struct packed {
    logic [CHAR_W-1:0] line_char;
    logic              last_char;
    logic              empty_line;
  } res_t;

  // output queue status seen by the back
  typedef struct packed {
    logic [1:0] cnt;
    logic       pop_fire;
  } outq_stat_t;

  // ring position of offset from base, wrapping at LINE_MAX
  function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] pos;
    pos = {1'b0, base} + {1'b0, off};
    if (pos >= (AW+1)'(LINE_MAX)) begin
      pos = pos - (AW+1)'(LINE_MAX);
    end
    return pos[AW-1:0];
  endfunction

endpackage

// ===== rtl/line_assembler_with_backspace_top.sv =====
// line_assembler_with_backspace_top: builds text lines from received bytes
// depends on lae_pkg, lae_front, lae_back, lae_outq
//
//  channel | ports                                    | beat taken when
//  --------+------------------------------------------+---------------------
//  input   | push, full, in_rx_byte                   | push && !full
//  result  | empty, pop, out_line_char/_last_char/    | pop && !empty
//          | out_empty_line                           |
//
// a byte is taken whenever the two-entry command queue has room;
// the back executes one command per cycle from its head; a line feed waits
// for room in the result queue and streams the held line at one beat per cycle
// from the ring's registered read port, holding the back until its last read
// synchronous active-low reset clears counters and queues; ring content
// needs no clearing, it is only read where it was written
module line_assembler_with_backspace_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [lae_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                               empty,
  input  logic                               pop,
  output logic [lae_pkg::CHAR_W-1:0]         out_line_char,
  output logic                               out_last_char,
  output logic                               out_empty_line
);

  logic                op_valid, op_pop, res_wr;
  lae_pkg::op_t        op;
  lae_pkg::outq_stat_t oq_stat;
  lae_pkg::res_t       res_bk, res_out;

  // byte intake and command queue
  lae_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .op_valid   (op_valid),
    .op         (op),
    .op_pop     (op_pop)
  );

  // ring store and line readout
  lae_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .oq_stat  (oq_stat),
    .res_wr   (res_wr),
    .res      (res_bk)
  );

  // result queue
  lae_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_wr  (res_wr),
    .res_in  (res_bk),
    .pop     (pop),
    .empty   (empty),
    .res_out (res_out),
    .stat    (oq_stat)
  );

  assign out_line_char  = res_out.line_char;
  assign out_last_char  = res_out.last_char;
  assign out_empty_line = res_out.empty_line;

endmodule

// ===== rtl/lae_front.sv =====
// lae_front: accepts received bytes, classifies them and queues commands
// depends on lae_pkg; feeds lae_back through a two-entry command queue
module lae_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [lae_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                         op_valid,
  output lae_pkg::op_t                 op,
  input  logic                         op_pop
);

  lae_pkg::op_t q_r [0:1];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         keep;
  lae_pkg::op_t op_new;
  logic         push_fire, wr_en, rd_en;

  // classify: carriage return and other unprintable bytes but LF, BS and DEL are dropped
  always_comb begin
    keep        = 1'b0;
    op_new.kind = lae_pkg::OP_APPEND;
    op_new.ch   = in_rx_byte[lae_pkg::CHAR_W-1:0];
    case (in_rx_byte)
      lae_pkg::BYTE_LF: begin
        keep        = 1'b1;
        op_new.kind = lae_pkg::OP_LFEED;
      end
      lae_pkg::BYTE_BS, lae_pkg::BYTE_DEL: begin
        keep        = 1'b1;
        op_new.kind = lae_pkg::OP_BKSP;
      end
      default: begin
        if (in_rx_byte inside {[lae_pkg::PRINT_LO:lae_pkg::PRINT_HI]}) begin
          keep = 1'b1;
        end
      end
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign push_fire = push && !full;
  assign wr_en     = push_fire && keep;
  assign op_valid  = (cnt_r != 2'd0);
  assign rd_en     = op_pop && op_valid;
  assign op        = q_r[rd_ptr_r];

  // command queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // command queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= op_new;
    end
  end

endmodule

// ===== rtl/lae_back.sv =====
// lae_back: executes commands on the character ring and streams lines out
// depends on lae_pkg; takes commands from lae_front, writes beats into lae_outq
module lae_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  input  lae_pkg::op_t        op,
  output logic                op_pop,
  input  lae_pkg::outq_stat_t oq_stat,
  output logic                res_wr,
  output lae_pkg::res_t       res
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [lae_pkg::AW-1:0]      oldest_r, oldest_nxt;
  logic [lae_pkg::CNT_W-1:0]   held_r, held_nxt;
  logic [lae_pkg::AW-1:0]      idx_r, idx_nxt;
  logic                        rd_vld_r, rd_last_r, rd_empty_r;
  logic [lae_pkg::CHAR_W-1:0]  mem_q_r;
  logic [lae_pkg::CHAR_W-1:0]  mem [0:lae_pkg::STORE_DEPTH-1];

  logic                        credit_ok;
  logic                        rd_issue, rd_last, rd_empty;
  logic [lae_pkg::AW-1:0]      rd_addr;
  logic                        wr_en;
  logic [lae_pkg::AW-1:0]      wr_addr;
  logic [lae_pkg::CHAR_W-1:0]  wr_data;

  // room in the output queue counting the beat in flight
  assign credit_ok = ({1'b0, oq_stat.cnt} + {2'b00, rd_vld_r}
                      - {2'b00, oq_stat.pop_fire}) < 3'd2;

  // command execution and line readout
  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    held_nxt   = held_r;
    idx_nxt    = idx_r;
    op_pop     = 1'b0;
    rd_issue   = 1'b0;
    rd_last    = 1'b0;
    rd_empty   = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = op.ch;
    case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          case (op.kind)
            lae_pkg::OP_APPEND: begin
              op_pop = 1'b1;
              wr_en  = 1'b1;
              if (held_r == lae_pkg::CNT_W'(lae_pkg::LINE_MAX)) begin
                // full: overwrite the oldest and move the start up
                wr_addr    = oldest_r;
                oldest_nxt = lae_pkg::ring_idx(oldest_r, lae_pkg::AW'(1));
              end else begin
                wr_addr  = lae_pkg::ring_idx(oldest_r, held_r[lae_pkg::AW-1:0]);
                held_nxt = held_r + lae_pkg::CNT_W'(1);
              end
            end
            lae_pkg::OP_BKSP: begin
              op_pop = 1'b1;
              if (held_r != '0) begin
                held_nxt = held_r - lae_pkg::CNT_W'(1);
              end
            end
            lae_pkg::OP_LFEED: begin
              if (held_r == '0) begin
                // empty line gives a single marker beat
                if (credit_ok) begin
                  op_pop     = 1'b1;
                  rd_issue   = 1'b1;
                  rd_last    = 1'b1;
                  rd_empty   = 1'b1;
                  oldest_nxt = '0;
                end
              end else begin
                op_pop    = 1'b1;
                idx_nxt   = '0;
                state_nxt = ST_EMIT;
              end
            end
            default: begin
              op_pop = 1'b1;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (credit_ok) begin
          rd_issue = 1'b1;
          rd_addr  = lae_pkg::ring_idx(oldest_r, idx_r);
          rd_last  = ({1'b0, idx_r} + lae_pkg::CNT_W'(1)) == held_r;
          if (rd_last) begin
            held_nxt   = '0;
            oldest_nxt = '0;
            state_nxt  = ST_IDLE;
          end else begin
            idx_nxt = idx_r + lae_pkg::AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, counters and the read pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      oldest_r   <= '0;
      held_r     <= '0;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      rd_last_r  <= 1'b0;
      rd_empty_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      oldest_r   <= oldest_nxt;
      held_r     <= held_nxt;
      idx_r      <= idx_nxt;
      rd_vld_r   <= rd_issue;
      rd_last_r  <= rd_last;
      rd_empty_r <= rd_empty;
    end
  end

  // character ring, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue && !rd_empty) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // beat toward the output queue
  assign res_wr         = rd_vld_r;
  assign res.line_char  = rd_empty_r ? '0 : mem_q_r;
  assign res.last_char  = rd_last_r;
  assign res.empty_line = rd_empty_r;

endmodule

// ===== rtl/lae_outq.sv =====
// lae_outq: two-entry result queue between the back and the result ports
// depends on lae_pkg; written by lae_back
module lae_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_wr,
  input  lae_pkg::res_t       res_in,
  input  logic                pop,
  output logic                empty,
  output lae_pkg::res_t       res_out,
  output lae_pkg::outq_stat_t stat
);

  lae_pkg::res_t q_r [0:1];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          rd_en;

  assign empty         = (cnt_r == 2'd0);
  assign rd_en         = pop && !empty;
  assign res_out       = q_r[rd_ptr_r];
  assign stat.cnt      = cnt_r;
  assign stat.pop_fire = rd_en;

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (res_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, res_wr} - {1'b0, rd_en};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (res_wr) begin
      q_r[wr_ptr_r] <= res_in;
    end
  end

endmodule

// ===== verif/line_tracker_pkg.sv =====
`timescale 1ns / 100ps
// line_tracker_pkg: tracks held text and predicts the character beats of each line
// depends on lae_pkg for widths, byte codes and the result beat type
package line_tracker_pkg;

  import lae_pkg::*;

  class line_tracker;

    // ring of held characters, oldest slot and fill level
    logic [CHAR_W-1:0] ring [STORE_DEPTH];
    logic [AW-1:0]     oldest;
    int unsigned       held;
    // character beats still owed by the block, oldest first
    res_t              beats_due[$];
    int unsigned       mismatches;

    function new();
      oldest     = '0;
      held       = 0;
      mismatches = 0;
    endfunction

    // ring slot at a given distance from the oldest character
    function logic [AW-1:0] slot(int unsigned off);
      return AW'((int'(oldest) + off) % LINE_MAX);
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction

    // update the held line for one accepted byte
    function void take_byte(logic [BYTE_W-1:0] b);
      res_t        r;
      int unsigned k;
      if (b == BYTE_LF) begin
        // line feed: a lone empty marker or every held character in order
        if (held == 0) begin
          r.line_char  = '0;
          r.last_char  = 1'b1;
          r.empty_line = 1'b1;
          beats_due.push_back(r);
        end else begin
          for (k = 0; k < held; k++) begin
            r.line_char  = ring[slot(k)];
            r.last_char  = (k + 1 == held);
            r.empty_line = 1'b0;
            beats_due.push_back(r);
          end
        end
        oldest = '0;
        held   = 0;
      end else if (b == BYTE_BS || b == BYTE_DEL) begin
        // erase the newest character, nothing on an empty line
        if (held > 0) held--;
      end else if (b >= PRINT_LO && b <= PRINT_HI) begin
        // append; a full line loses its oldest character
        if (held < LINE_MAX) begin
          ring[slot(held)] = b[CHAR_W-1:0];
          held++;
        end else begin
          ring[slot(0)] = b[CHAR_W-1:0];
          oldest        = slot(1);
        end
      end
      // carriage return and every other byte leave the line untouched
    endfunction

    // compare one result beat with the oldest one owed
    function void check_char(logic [CHAR_W-1:0] ch, logic last, logic no_chars);
      res_t got;
      res_t want;
      got.line_char  = ch;
      got.last_char  = last;
      got.empty_line = no_chars;
      if (beats_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat char %h last %b empty %b",
                 $time, ch, last, no_chars);
        return;
      end
      want = beats_due.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: beat mismatch expected char %h last %b empty %b,",
                 $time, want.line_char, want.last_char, want.empty_line,
                 " got char %h last %b empty %b",
                 got.line_char, got.last_char, got.empty_line);
      end
    endfunction

  endclass

endpackage

// ===== verif/tb_line_assembler_with_backspace_top.sv =====
`timescale 1ns / 100ps
// tb_line_assembler_with_backspace_top: drives bytes into the line assembler and checks its beats
// depends on lae_pkg, line_tracker_pkg and line_assembler_with_backspace_top
module tb_line_assembler_with_backspace_top;

  import lae_pkg::*;
  import line_tracker_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int ITEM_GOAL   = 260;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              empty;
  logic              pop;
  logic [CHAR_W-1:0] out_line_char;
  logic              out_last_char;
  logic              out_empty_line;

  line_tracker tracker;

  int unsigned useful_sent;
  int unsigned send_beats;
  int unsigned recv_beats;
  bit          send_calm;
  bit          recv_calm;

  line_assembler_with_backspace_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_rx_byte    (in_rx_byte),
    .empty         (empty),
    .pop           (pop),
    .out_line_char (out_line_char),
    .out_last_char (out_last_char),
    .out_empty_line(out_empty_line)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) tracker.take_byte(in_rx_byte);
      if (pop && !empty) tracker.check_char(out_line_char, out_last_char, out_empty_line);
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((push && !full) || (pop && !empty))) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // offer one byte after a random gap and wait for its beat
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (send_beats % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
    send_beats++;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    if (b == BYTE_LF || b == BYTE_BS || b == BYTE_DEL || (b >= PRINT_LO && b <= PRINT_HI))
      useful_sent++;
  endtask

  // hold off until the block owes nothing, after first letting the monitor
  // note the last accepted byte
  task automatic wait_drained();
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // one line of random content closed by a line feed
  task automatic send_line(input int unsigned len, input bit edits);
    int unsigned k;
    int unsigned pick;
    logic [BYTE_W-1:0] b;
    for (k = 0; k < len; k++) begin
      pick = edits ? $urandom_range(0, 99) : 99;
      if (pick < 6) b = pick[0] ? BYTE_BS : BYTE_DEL;
      else if (pick < 9) b = BYTE_CR;
      else if (pick < 11) b = 8'($urandom_range(128, 255));
      else if (pick < 13) b = 8'($urandom_range(0, 31));
      else b = 8'($urandom_range(PRINT_LO, PRINT_HI));
      // stray line feeds would split the line
      if (b == BYTE_LF) b = BYTE_CR;
      send_byte(b);
    end
    send_byte(BYTE_LF);
  endtask

  // receiver: takes beats after random stalls
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (recv_beats % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      recv_beats++;
      gap = recv_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // sender: opening cases, then random lines
  initial begin
    logic [BYTE_W-1:0] opening [22];
    int unsigned       k;
    int unsigned       line_no;
    int unsigned       len;
    tracker     = new();
    useful_sent = 0;
    send_beats  = 0;
    recv_beats  = 0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    rst_n      <= 1'b0;
    push       <= 1'b0;
    pop        <= 1'b0;
    in_rx_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty line, erase on nothing, ignored bytes, printable extremes, erase and close
    opening = '{BYTE_LF, BYTE_BS, BYTE_DEL, BYTE_CR, 8'd0, 8'd255, 8'd128, 8'd31,
                PRINT_LO, PRINT_HI, 8'h55, 8'h2a, BYTE_BS, BYTE_CR, 8'h41, 8'h3f,
                BYTE_DEL, 8'h7e, 8'h40, 8'd9, BYTE_LF, BYTE_LF};
    for (k = 0; k < 22; k++) send_byte(opening[k]);

    // let every owed beat come out before the random part
    push <= 1'b0;
    wait_drained();

    // mostly short lines, one exactly full, one overflowing with edits
    line_no = 0;
    while (useful_sent < ITEM_GOAL) begin
      if (line_no == 2) begin
        send_line(LINE_MAX, 1'b0);
      end else if (line_no == 5) begin
        send_line(LINE_MAX + $urandom_range(5, 20), 1'b1);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
        send_line(len, 1'b1);
      end
      line_no++;
    end

    // drain and settle
    push <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
